### design/sxefd_pkg.sv
package sxefd_pkg;

  localparam logic [7:0] SyncReset    = 8'hAA;
  localparam logic [7:0] TypeKey      = 8'h01;
  localparam logic [7:0] TypePointer  = 8'h02;
  localparam logic [3:0] LenKey       = 4'd6;
  localparam logic [3:0] LenPointer   = 4'd8;
  localparam int unsigned PayloadDepth = 5;
  localparam int unsigned SlotW        = 3;

  // register index of sync_byte
  localparam logic RegSync = 1'b0;

  typedef enum logic [1:0] {
    STAT_KEY       = 2'd0,
    STAT_POINTER   = 2'd1,
    STAT_BAD_TYPE  = 2'd2,
    STAT_BAD_CHECK = 2'd3
  } status_e;

  // what the parser tells the result side to do
  typedef enum logic [2:0] {
    TOK_PAYLOAD   = 3'd0,
    TOK_KEY       = 3'd1,
    TOK_POINTER   = 3'd2,
    TOK_BAD_TYPE  = 3'd3,
    TOK_BAD_CHECK = 3'd4
  } tok_e;

  typedef struct packed {
    tok_e             kind;
    logic [SlotW-1:0] slot;
    logic [7:0]       data;
  } token_t;

endpackage

### design/sxefd_front.sv
module sxefd_front
  import sxefd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] sync_byte_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output token_t     token_o
);

  logic [3:0] pos_q, pos_d;
  logic [3:0] len_q, len_d;
  logic [7:0] xor_q, xor_d;
  logic       accept;
  logic [3:0] slot_full;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign slot_full  = pos_q - 4'd2;

  always_comb begin
    pos_d        = pos_q;
    len_d        = len_q;
    xor_d        = xor_q;
    push_o       = 1'b0;
    token_o.kind = TOK_PAYLOAD;
    token_o.slot = slot_full[SlotW-1:0];
    token_o.data = rx_byte_i;
    if (accept) begin
      if (pos_q == 4'd0) begin
        if (rx_byte_i == sync_byte_i) begin
          pos_d = 4'd1;
          len_d = 4'd0;
          xor_d = 8'd0;
        end
      end else if (pos_q == 4'd1) begin
        if (rx_byte_i == TypeKey || rx_byte_i == TypePointer) begin
          len_d = (rx_byte_i == TypeKey) ? LenKey : LenPointer;
          xor_d = rx_byte_i;
          pos_d = 4'd2;
        end else begin
          push_o       = 1'b1;
          token_o.kind = TOK_BAD_TYPE;
          pos_d        = 4'd0;
          len_d        = 4'd0;
          xor_d        = 8'd0;
        end
      end else if (len_q != LenKey && len_q != LenPointer) begin
        // cannot happen; fall back to hunting
        pos_d = 4'd0;
        len_d = 4'd0;
        xor_d = 8'd0;
      end else if (pos_q + 4'd1 < len_q) begin
        push_o = 1'b1;
        xor_d  = xor_q ^ rx_byte_i;
        pos_d  = pos_q + 4'd1;
      end else begin
        push_o = 1'b1;
        if (rx_byte_i != xor_q) begin
          token_o.kind = TOK_BAD_CHECK;
        end else if (len_q == LenKey) begin
          token_o.kind = TOK_KEY;
        end else begin
          token_o.kind = TOK_POINTER;
        end
        pos_d = 4'd0;
        len_d = 4'd0;
        xor_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      len_q <= 4'd0;
      xor_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      xor_q <= xor_d;
    end
  end

  a_len_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q >= 4'd2 |-> (len_q == LenKey || len_q == LenPointer))
    else $error("frame length unknown past the type byte");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q >= 4'd2 |-> pos_q < len_q)
    else $error("frame position ran past the check byte");

  a_payload_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && token_o.kind == TOK_PAYLOAD |-> token_o.slot < SlotW'(PayloadDepth))
    else $error("payload slot out of range");

endmodule

### design/sxefd_fifo.sv
module sxefd_fifo
  import sxefd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t token_i,
  output logic   full_o,
  input  logic   pop_i,
  output token_t token_o,
  output logic   empty_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [IdxW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign token_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("transfer pushed into a full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

### design/sxefd_back.sv
module sxefd_back
  import sxefd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  token_t            token_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        key_row_o,
  output logic [7:0]        key_col_o,
  output logic              key_pressed_o,
  output logic signed [7:0] move_x_o,
  output logic signed [7:0] move_y_o,
  output logic signed [7:0] wheel_vertical_o,
  output logic signed [7:0] wheel_horizontal_o,
  output logic [7:0]        button_bits_o
);

  logic [7:0] store_q [PayloadDepth];
  logic       valid_q;
  logic       load;
  status_e    stat_d;
  logic [7:0] row_d, col_d, btn_d;
  logic       press_d;
  logic signed [7:0] mx_d, my_d, wv_d, wh_d;

  // a result token fills the output stage; payload tokens only touch the store
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);
  assign load  = pop_o && (token_i.kind != TOK_PAYLOAD);

  always_comb begin
    stat_d  = STAT_BAD_CHECK;
    row_d   = 8'd0;
    col_d   = 8'd0;
    press_d = 1'b0;
    mx_d    = 8'sd0;
    my_d    = 8'sd0;
    wv_d    = 8'sd0;
    wh_d    = 8'sd0;
    btn_d   = 8'd0;
    case (token_i.kind)
      TOK_KEY: begin
        stat_d  = STAT_KEY;
        row_d   = store_q[0];
        col_d   = store_q[1];
        press_d = (store_q[2] != 8'd0);
      end
      TOK_POINTER: begin
        stat_d = STAT_POINTER;
        mx_d   = store_q[0];
        my_d   = store_q[1];
        wv_d   = store_q[2];
        wh_d   = store_q[3];
        btn_d  = store_q[4];
      end
      TOK_BAD_TYPE: begin
        stat_d = STAT_BAD_TYPE;
      end
      default: begin
        stat_d = STAT_BAD_CHECK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && token_i.kind == TOK_PAYLOAD) begin
      store_q[token_i.slot] <= token_i.data;
    end
    if (load) begin
      status_o           <= stat_d;
      key_row_o          <= row_d;
      key_col_o          <= col_d;
      key_pressed_o      <= press_d;
      move_x_o           <= mx_d;
      move_y_o           <= my_d;
      wheel_vertical_o   <= wv_d;
      wheel_horizontal_o <= wh_d;
      button_bits_o      <= btn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;

  a_no_pop_on_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |-> !load)
    else $error("result overwritten while stalled");

endmodule

### design/sync_xor_event_frame_decoder_unit.sv
// Sync/XOR framed event decoder. Serial bytes come in on rx_byte_i, one per
// transfer, and one byte is taken every clock cycle as long as the internal
// token queue (QueueDepth entries) has room. The parser hunts for the sync
// byte (register 0, reset 0xAA), reads the type byte and tracks the running
// XOR; the result side collects payload bytes and delivers one result per
// frame: key event, pointer event, bad type or checksum mismatch. A result
// token is registered in the token queue and then in the output stage. Stalls
// on the output fill the queue before input is stalled.
module sync_xor_event_frame_decoder_unit
  import sxefd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        key_row_o,
  output logic [7:0]        key_col_o,
  output logic              key_pressed_o,
  output logic signed [7:0] move_x_o,
  output logic signed [7:0] move_y_o,
  output logic signed [7:0] wheel_vertical_o,
  output logic signed [7:0] wheel_horizontal_o,
  output logic [7:0]        button_bits_o
);

  logic [7:0] sync_q;
  logic       sel_sync;
  logic       push, pop, full, empty;
  token_t     push_tok, pop_tok;

  assign pready   = 1'b1;
  assign sel_sync = (paddr[2] == RegSync);
  assign prdata   = sel_sync ? {24'd0, sync_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else if (psel && penable && pwrite && sel_sync) begin
      sync_q <= pwdata[7:0];
    end
  end

  sxefd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sync_byte_i (sync_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .full_i      (full),
    .push_o      (push),
    .token_o     (push_tok)
  );

  sxefd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_tok),
    .full_o  (full),
    .pop_i   (pop),
    .token_o (pop_tok),
    .empty_o (empty)
  );

  sxefd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .token_i            (pop_tok),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .key_row_o          (key_row_o),
    .key_col_o          (key_col_o),
    .key_pressed_o      (key_pressed_o),
    .move_x_o           (move_x_o),
    .move_y_o           (move_y_o),
    .wheel_vertical_o   (wheel_vertical_o),
    .wheel_horizontal_o (wheel_horizontal_o),
    .button_bits_o      (button_bits_o)
  );

endmodule

### verif/sxefd_frame_checker.sv
`timescale 1ns / 100ps

module sxefd_frame_checker
  import sxefd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [1:0]        status_o,
  input  logic [7:0]        key_row_o,
  input  logic [7:0]        key_col_o,
  input  logic              key_pressed_o,
  input  logic signed [7:0] move_x_o,
  input  logic signed [7:0] move_y_o,
  input  logic signed [7:0] wheel_vertical_o,
  input  logic signed [7:0] wheel_horizontal_o,
  input  logic [7:0]        button_bits_o,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    status_e           status;
    logic [7:0]        key_row;
    logic [7:0]        key_col;
    logic              key_pressed;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_vertical;
    logic signed [7:0] wheel_horizontal;
    logic [7:0]        button_bits;
  } frame_event_t;

  frame_event_t expected_events[$];

  logic [7:0] sync_val;
  logic [3:0] frame_pos;
  logic [3:0] frame_len;
  logic [7:0] xor_acc;
  logic [7:0] payload [PayloadDepth];

  task automatic restart_hunt();
    frame_pos = '0;
    frame_len = '0;
    xor_acc   = '0;
  endtask

  // advance the frame parser by one byte, queueing any event it completes
  task automatic decode_byte(input logic [7:0] b);
    frame_event_t ev;
    logic         emit;
    ev   = '0;
    emit = 1'b0;
    if (frame_pos == 4'd0) begin
      if (b == sync_val) begin
        frame_pos = 4'd1;
        frame_len = '0;
        xor_acc   = '0;
      end
    end else if (frame_pos == 4'd1) begin
      if (b == TypeKey || b == TypePointer) begin
        frame_len = (b == TypeKey) ? LenKey : LenPointer;
        xor_acc   = b;
        frame_pos = 4'd2;
      end else begin
        ev.status = STAT_BAD_TYPE;
        emit      = 1'b1;
        restart_hunt();
      end
    end else if (frame_pos + 1 < frame_len) begin
      payload[frame_pos - 4'd2] = b;
      xor_acc   = xor_acc ^ b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      emit = 1'b1;
      if (b != xor_acc) begin
        ev.status = STAT_BAD_CHECK;
      end else if (frame_len == LenKey) begin
        ev.status      = STAT_KEY;
        ev.key_row     = payload[0];
        ev.key_col     = payload[1];
        ev.key_pressed = (payload[2] != 8'd0);
      end else begin
        ev.status           = STAT_POINTER;
        ev.move_x           = payload[0];
        ev.move_y           = payload[1];
        ev.wheel_vertical   = payload[2];
        ev.wheel_horizontal = payload[3];
        ev.button_bits      = payload[4];
      end
      restart_hunt();
    end
    if (emit) expected_events.push_back(ev);
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_event_t exp_ev;
    if (!rst_ni) begin
      expected_events.delete();
      sync_val   = SyncReset;
      restart_hunt();
      foreach (payload[i]) payload[i] = '0;
      fail_count = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegSync)
        sync_val = pwdata[7:0];
      if (in_valid_i && !in_stall_o)
        decode_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $error("result transfer with nothing expected: status %0d", status_o);
          fail_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          check_field("status", exp_ev.status, status_o);
          check_field("key_row", exp_ev.key_row, key_row_o);
          check_field("key_col", exp_ev.key_col, key_col_o);
          check_field("key_pressed", exp_ev.key_pressed, key_pressed_o);
          check_field("move_x", exp_ev.move_x, move_x_o);
          check_field("move_y", exp_ev.move_y, move_y_o);
          check_field("wheel_vertical", exp_ev.wheel_vertical, wheel_vertical_o);
          check_field("wheel_horizontal", exp_ev.wheel_horizontal, wheel_horizontal_o);
          check_field("button_bits", exp_ev.button_bits, button_bits_o);
        end
      end
      pending = expected_events.size();
    end
  end

endmodule

### verif/sync_xor_event_frame_decoder_unit_tb.sv
`timescale 1ns / 100ps

module sync_xor_event_frame_decoder_unit_tb;
  import sxefd_pkg::*;

  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned SettleTail  = 12;
  localparam int unsigned CycleLimit  = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [7:0]        key_row_o;
  logic [7:0]        key_col_o;
  logic              key_pressed_o;
  logic signed [7:0] move_x_o;
  logic signed [7:0] move_y_o;
  logic signed [7:0] wheel_vertical_o;
  logic signed [7:0] wheel_horizontal_o;
  logic [7:0]        button_bits_o;

  int          fail_count;
  int          pending;
  int unsigned cycle_count;
  int unsigned sent_bytes;
  int unsigned hold_requests;
  int unsigned holds_served;
  bit          idle_on;
  logic [7:0]  cur_sync;

  sync_xor_event_frame_decoder_unit dut (.*);

  sxefd_frame_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sync_xor_event_frame_decoder_unit test failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_stall_i  = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        holds_served++;
      end else begin
        out_stall_i = idle_on && ($urandom_range(99) < 19);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid_i = 1'b0;
      rx_byte_i  = 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    sent_bytes++;
  endtask

  // sync, type, payload and check; a bad type ends the frame after the type byte
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
                            input bit spoil);
    logic [7:0] chk;
    send_byte(cur_sync);
    send_byte(ftype);
    if (ftype == TypeKey || ftype == TypePointer) begin
      send_byte(a);
      send_byte(b);
      send_byte(c);
      chk = ftype ^ a ^ b ^ c;
      if (ftype == TypePointer) begin
        send_byte(d);
        send_byte(e);
        chk = chk ^ d ^ e;
      end
      if (spoil) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(chk);
    end
  endtask

  task automatic send_random_traffic(input int unsigned nbytes);
    int unsigned start;
    int unsigned roll;
    logic [7:0]  ftype;
    logic [7:0]  pressed;
    start = sent_bytes;
    while (sent_bytes - start < nbytes) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        send_byte(8'($urandom));
      end else begin
        if (roll < 50)      ftype = TypeKey;
        else if (roll < 92) ftype = TypePointer;
        else                ftype = 8'($urandom);
        pressed = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        send_frame(ftype, 8'($urandom), 8'($urandom), pressed, 8'($urandom), 8'($urandom),
                   $urandom_range(99) < 10);
      end
    end
  endtask

  // drop valid and wait for all results, plus time for queued payload tokens
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (SettleTail) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (addr[2] == RegSync) cur_sync = data[7:0];
  endtask

  initial begin
    logic [7:0] mid_a;
    logic [7:0] mid_b;
    logic [7:0] mid_d;
    logic [7:0] mid_e;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    cycle_count   = 0;
    sent_bytes    = 0;
    hold_requests = 0;
    idle_on       = 1'b1;
    cur_sync      = SyncReset;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: ignored byte while hunting, sync value as payload, type equal
    // to sync (bad type, next byte re-hunted), signed extremes, bad check
    send_byte(8'h00);
    send_frame(TypeKey, 8'hAA, 8'hFF, 8'h80, 8'h00, 8'h00, 1'b0);
    send_frame(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_frame(TypePointer, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h55, 1'b0);
    send_frame(TypeKey, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    settle();

    // sync at zero; receiver holds off while the sender keeps pushing
    cfg_write(3'd0, 32'h0000_0000);
    hold_requests++;
    send_random_traffic(200);
    settle();

    // sync at all ones, no idling on either side
    cfg_write(3'd0, 32'h0000_00FF);
    idle_on = 1'b0;
    send_random_traffic(150);
    idle_on = 1'b1;
    settle();

    // unmapped register is ignored
    cfg_write(3'd0, 32'($urandom));
    cfg_write(3'd4, 32'h0000_0033);
    send_random_traffic(200);
    settle();

    // sync changed in the middle of a pointer frame: only matters when hunting
    mid_a = 8'($urandom);
    mid_b = 8'($urandom);
    mid_d = 8'($urandom);
    mid_e = 8'($urandom);
    send_byte(cur_sync);
    send_byte(TypePointer);
    send_byte(mid_a);
    send_byte(mid_b);
    settle();
    cfg_write(3'd0, 32'h0000_005A);
    send_byte(8'h5A);
    send_byte(mid_d);
    send_byte(mid_e);
    send_byte(TypePointer ^ mid_a ^ mid_b ^ 8'h5A ^ mid_d ^ mid_e);
    send_random_traffic(120);
    settle();

    cfg_write(3'd0, 32'h0000_00AA);
    send_random_traffic(130);
    settle();

    if (fail_count == 0)
      $display("sync_xor_event_frame_decoder_unit test passed");
    else
      $display("sync_xor_event_frame_decoder_unit test failed");
    $finish;
  end

endmodule
